[hdl/assert_macros.svh]
// Assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/rms_pkg.sv]
package rms_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int ADC_BITS   = 12;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SQ_W   = 2 * ADC_BITS;
  localparam int SUM_W  = SQ_W + $clog2(MAX_WINDOW);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int WORK_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int GAIN_W = 24;
  localparam int PROD_W = ROOT_W + GAIN_W;
  localparam int OUT_W  = 32;

  localparam int DIV_STEPS  = WORK_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CNT_W-1:0]    WINDOW_RESET = CNT_W'(400);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(65536);
  localparam logic [ADC_BITS-1:0] OFFSET_RESET = ADC_BITS'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 2'd0,
    CFG_VOLTAGE_GAIN   = 2'd1,
    CFG_CURRENT_OFFSET = 2'd2,
    CFG_CURRENT_GAIN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_MUL,
    ST_SAVE,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic mul;
    logic save_v;
    logic store;
    logic chan;
  } cmd_t;

  typedef struct packed {
    logic window_full;
  } status_t;

endpackage

[hdl/rms_ifs.sv]
interface rms_in_if;
  import rms_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] voltage_code;
  logic [ADC_BITS-1:0] current_code;

  modport source (output valid, output voltage_code, output current_code, input ready);
  modport sink   (input valid, input voltage_code, input current_code, output ready);
endinterface

interface rms_out_if;
  import rms_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] voltage_rms;
  logic [OUT_W-1:0] current_rms;

  modport source (output valid, output voltage_rms, output current_rms, input ready);
  modport sink   (input valid, input voltage_rms, input current_rms, output ready);
endinterface

[hdl/dual_channel_rms_meter.sv]
// True RMS meter for one voltage and one current channel. Each item is a pair of 12-bit ADC
// codes; the current code has the configured offset code removed, both values are squared and
// summed, and after window_length pairs (0 counts as 1, values above 1024 count as 1024) one
// result carries both RMS values: floor(sqrt(floor(sum / length))) times the channel's Q8.16
// gain, as Q16.16 saturated to all ones. An ordinary item occupies the input through the load,
// square and accumulate states. The item that closes a window then runs the shared restoring
// divider, the shared root unit and the gain multiply, for voltage and then current; it waits
// in the store state only while an earlier result still sits unread in the output register.
// Configuration writes take effect on the next cycle.
`include "assert_macros.svh"

module dual_channel_rms_meter (
  input  logic                           clk,
  input  logic                           rst,
  rms_in_if.sink                         in_ch,
  rms_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rms_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import rms_pkg::*;

  cmd_t    cmd;
  status_t status;

  rms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  rms_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .voltage_code (in_ch.voltage_code),
    .current_code (in_ch.current_code),
    .cmd          (cmd),
    .status       (status),
    .voltage_rms  (out_ch.voltage_rms),
    .current_rms  (out_ch.current_rms)
  );

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMPL(a_store_into_free_reg, clk, rst, cmd.store, !out_ch.valid || out_ch.ready)
  `ASSERT_ALWAYS(a_single_command, clk, rst, $onehot0({cmd.load_in, cmd.square, cmd.accum, cmd.div_load, cmd.div_step, cmd.root_load, cmd.root_step, cmd.mul, cmd.save_v, cmd.store}))

endmodule

[hdl/rms_datapath.sv]
module rms_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rms_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [rms_pkg::ADC_BITS-1:0]   voltage_code,
  input  logic [rms_pkg::ADC_BITS-1:0]   current_code,
  input  rms_pkg::cmd_t                  cmd,
  output rms_pkg::status_t               status,
  output logic [rms_pkg::OUT_W-1:0]      voltage_rms,
  output logic [rms_pkg::OUT_W-1:0]      current_rms
);
  import rms_pkg::*;

  logic [CNT_W-1:0]    window_length;
  logic [GAIN_W-1:0]   voltage_gain;
  logic [ADC_BITS-1:0] current_offset_code;
  logic [GAIN_W-1:0]   current_gain;

  logic [SUM_W-1:0]    voltage_square_sum;
  logic [SUM_W-1:0]    current_square_sum;
  logic [CNT_W-1:0]    pairs_seen;

  logic [ADC_BITS-1:0] v_reg;
  logic [ADC_BITS-1:0] mag_reg;
  logic [SQ_W-1:0]     sq_v;
  logic [SQ_W-1:0]     sq_c;
  logic [WORK_W-1:0]   work;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root;
  logic [PROD_W-1:0]   prod;
  logic [OUT_W-1:0]    v_result;

  logic [CNT_W-1:0]    len_eff;
  logic [ADC_BITS-1:0] mag;
  logic [CNT_W:0]      div_trial;
  logic                div_ge;
  logic [REM_W-1:0]    rt_trial;
  logic [REM_W-1:0]    rt_test;
  logic                rt_ge;
  logic [OUT_W-1:0]    prod_sat;
  logic [GAIN_W-1:0]   gain_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length       <= WINDOW_RESET;
      voltage_gain        <= GAIN_RESET;
      current_offset_code <= OFFSET_RESET;
      current_gain        <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:  window_length       <= cfg_wr_data[CNT_W-1:0];
        CFG_VOLTAGE_GAIN:   voltage_gain        <= cfg_wr_data[GAIN_W-1:0];
        CFG_CURRENT_OFFSET: current_offset_code <= cfg_wr_data[ADC_BITS-1:0];
        CFG_CURRENT_GAIN:   current_gain        <= cfg_wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (window_length > CNT_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
  end

  assign mag = (current_code >= current_offset_code) ? current_code - current_offset_code
                                                     : current_offset_code - current_code;

  assign status.window_full = ({1'b0, pairs_seen} + (CNT_W+1)'(1)) >= {1'b0, len_eff};

  assign div_trial = {rem[CNT_W-1:0], work[WORK_W-1]};
  assign div_ge    = div_trial >= {1'b0, len_eff};

  assign rt_trial = {rem[REM_W-3:0], work[WORK_W-1:WORK_W-2]};
  assign rt_test  = {root, 2'b01};
  assign rt_ge    = rt_trial >= rt_test;

  assign gain_sel = cmd.chan ? current_gain : voltage_gain;
  assign prod_sat = (|prod[PROD_W-1:OUT_W]) ? '1 : prod[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_square_sum <= '0;
      current_square_sum <= '0;
      pairs_seen         <= '0;
    end else if (cmd.store) begin
      voltage_square_sum <= '0;
      current_square_sum <= '0;
      pairs_seen         <= '0;
    end else if (cmd.accum) begin
      voltage_square_sum <= voltage_square_sum + SUM_W'(sq_v);
      current_square_sum <= current_square_sum + SUM_W'(sq_c);
      pairs_seen         <= pairs_seen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_reg   <= voltage_code;
      mag_reg <= mag;
    end
    if (cmd.square) begin
      sq_v <= SQ_W'(v_reg) * SQ_W'(v_reg);
      sq_c <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
    end
    if (cmd.div_load) begin
      work <= WORK_W'(cmd.chan ? current_square_sum : voltage_square_sum);
      rem  <= '0;
    end else if (cmd.div_step) begin
      work <= {work[WORK_W-2:0], div_ge};
      rem  <= REM_W'(div_ge ? div_trial - {1'b0, len_eff} : div_trial);
    end else if (cmd.root_load) begin
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      work <= {work[WORK_W-3:0], 2'b00};
      rem  <= rt_ge ? rt_trial - rt_test : rt_trial;
      root <= {root[ROOT_W-2:0], rt_ge};
    end
    if (cmd.mul) begin
      prod <= PROD_W'(root) * PROD_W'(gain_sel);
    end
    if (cmd.save_v) begin
      v_result <= prod_sat;
    end
    if (cmd.store) begin
      voltage_rms <= v_result;
      current_rms <= prod_sat;
    end
  end

endmodule

[hdl/rms_ctrl.sv]
module rms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  rms_pkg::status_t status,
  output logic             in_ready,
  output logic             out_valid,
  output rms_pkg::cmd_t    cmd
);
  import rms_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;
  logic              chan;
  logic              chan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      chan     <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      chan     <= chan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    chan_next     = chan;
    cmd           = '0;
    cmd.chan      = chan;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        if (status.window_full) begin
          chan_next  = 1'b0;
          state_next = ST_DIV_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load  = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = chan ? ST_STORE : ST_SAVE;
      end
      ST_SAVE: begin
        cmd.save_v = 1'b1;
        chan_next  = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_STORE: begin
        if (!out_valid || out_ready) begin
          cmd.store  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/dual_channel_rms_meter_test.sv]
module dual_channel_rms_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rms_pkg::*;

  localparam int LIMIT       = 1000000;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_GOAL = 1450;

  typedef struct packed {
    logic [ADC_BITS-1:0] v;
    logic [ADC_BITS-1:0] c;
  } code_pair_t;

  typedef struct packed {
    logic [OUT_W-1:0] v;
    logic [OUT_W-1:0] c;
  } rms_pair_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  rms_in_if in_ch();
  rms_out_if out_ch();

  dual_channel_rms_meter u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // meter state as the block should hold it
  logic [CNT_W-1:0]    win_reg  = WINDOW_RESET;
  logic [GAIN_W-1:0]   v_gain   = GAIN_RESET;
  logic [ADC_BITS-1:0] c_offset = OFFSET_RESET;
  logic [GAIN_W-1:0]   c_gain   = GAIN_RESET;
  logic [63:0]         v_sq_sum = '0;
  logic [63:0]         c_sq_sum = '0;
  int unsigned         pairs_in_window = 0;

  code_pair_t  pending_pairs[$];
  rms_pair_t   rms_due[$];
  int unsigned pushed_pairs = 0;
  int unsigned taken_pairs = 0;
  int unsigned rms_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic calm = 1'b0;
  logic in_taken = 1'b0;

  function automatic logic [OUT_W-1:0] scaled_root(logic [63:0] sum, int unsigned len,
                                                  logic [GAIN_W-1:0] gain);
    logic [63:0] mean;
    logic [63:0] prod;
    logic [31:0] root;
    logic [31:0] trial;
    mean = sum / len;
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= mean) root = trial;
    end
    prod = 64'(root) * 64'(gain);
    return (prod > 64'hFFFF_FFFF) ? '1 : prod[OUT_W-1:0];
  endfunction

  function automatic void absorb_pair(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] c);
    int unsigned len;
    logic [ADC_BITS-1:0] mag;
    rms_pair_t r;
    len = win_reg;
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    mag = (c >= c_offset) ? c - c_offset : c_offset - c;
    v_sq_sum += 64'(v) * 64'(v);
    c_sq_sum += 64'(mag) * 64'(mag);
    pairs_in_window++;
    if (pairs_in_window >= len) begin
      r.v = scaled_root(v_sq_sum, len, v_gain);
      r.c = scaled_root(c_sq_sum, len, c_gain);
      rms_due.push_back(r);
      v_sq_sum = '0;
      c_sq_sum = '0;
      pairs_in_window = 0;
    end
  endfunction

  function automatic void note_error(string msg);
    rms_errors++;
    if (rms_errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_rms(logic [OUT_W-1:0] v, logic [OUT_W-1:0] c);
    rms_pair_t want;
    if (rms_due.size() == 0) begin
      note_error($sformatf("unexpected result voltage_rms=%h current_rms=%h", v, c));
    end else begin
      want = rms_due.pop_front();
      if (v !== want.v)
        note_error($sformatf("voltage_rms expected %h got %h", want.v, v));
      if (c !== want.c)
        note_error($sformatf("current_rms expected %h got %h", want.c, c));
    end
  endfunction

  function automatic void push_pair(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] c);
    code_pair_t p;
    p.v = v;
    p.c = c;
    pending_pairs.push_back(p);
    pushed_pairs++;
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ADC_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return GAIN_RESET;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'($urandom_range(13, 48));
      default: return CNT_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    case (idx)
      CFG_WINDOW_LENGTH:  win_reg = data[CNT_W-1:0];
      CFG_VOLTAGE_GAIN:   v_gain = data[GAIN_W-1:0];
      CFG_CURRENT_OFFSET: c_offset = data[ADC_BITS-1:0];
      CFG_CURRENT_GAIN:   c_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every item and result, then let the block go quiet
  task automatic drain();
    while (taken_pairs != pushed_pairs || rms_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("dual_channel_rms_meter_test: FAIL");
      $finish;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (!rst && in_ch.valid && in_ch.ready) begin
        taken_pairs <= taken_pairs + 1;
        absorb_pair(in_ch.voltage_code, in_ch.current_code);
      end
      if (!rst && out_ch.valid && out_ch.ready)
        check_rms(out_ch.voltage_rms, out_ch.current_rms);
    end
  end

  always @(negedge clk) begin
    if (in_ch.valid && !in_taken) begin
      // hold the offered item
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= $urandom_range(0, 15);
    end else if (pending_pairs.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.voltage_code <= pending_pairs[0].v;
      in_ch.current_code <= pending_pairs[0].c;
      void'(pending_pairs.pop_front());
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= $urandom_range(0, 15);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned n;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.voltage_code = '0;
    in_ch.current_code = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero window acts as one pair; gains and offset at reset values
    write_reg(CFG_WINDOW_LENGTH, '0);
    end_writes();
    push_pair('0, '0);
    push_pair('1, '1);
    push_pair('1, '0);
    push_pair('0, 12'd2048);
    push_pair(12'd2048, 12'd2047);

    drain();
    write_reg(CFG_VOLTAGE_GAIN, '1);
    write_reg(CFG_CURRENT_OFFSET, '0);
    write_reg(CFG_CURRENT_GAIN, '0);
    end_writes();
    push_pair('1, '1);
    push_pair(12'd1, 12'd1);
    push_pair(12'hAAA, 12'h555);

    drain();
    write_reg(CFG_VOLTAGE_GAIN, '0);
    write_reg(CFG_CURRENT_OFFSET, '1);
    write_reg(CFG_CURRENT_GAIN, '1);
    end_writes();
    push_pair(12'h555, '0);
    push_pair('1, '1);

    // shorten the window after five pairs; the next pair closes it
    drain();
    write_reg(CFG_WINDOW_LENGTH, 24'd10);
    write_reg(CFG_CURRENT_OFFSET, 24'd2048);
    write_reg(CFG_VOLTAGE_GAIN, 24'd65536);
    write_reg(CFG_CURRENT_GAIN, 24'h123456);
    end_writes();
    repeat (5) push_pair(pick_code(), pick_code());
    drain();
    write_reg(CFG_WINDOW_LENGTH, 24'd3);
    end_writes();
    push_pair(pick_code(), pick_code());

    // oversized window clamps to the maximum; full-scale voltage saturates
    drain();
    write_reg(CFG_WINDOW_LENGTH, 24'd2047);
    write_reg(CFG_VOLTAGE_GAIN, '1);
    write_reg(CFG_CURRENT_GAIN, 24'd65536);
    end_writes();
    for (int i = 0; i < MAX_WINDOW; i++) push_pair('1, ADC_BITS'($urandom));
    random_items += MAX_WINDOW;

    // stall the output long enough to back up the input
    drain();
    write_reg(CFG_WINDOW_LENGTH, 24'd1);
    end_writes();
    hold_asks = hold_asks + 1;
    for (int i = 0; i < 40; i++) push_pair(pick_code(), pick_code());
    random_items += 40;

    while (random_items < RANDOM_GOAL) begin
      drain();
      if (random_items >= RANDOM_GOAL - 150) calm = 1'b1;
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_WINDOW_LENGTH, {13'($urandom), pick_window()});
      if ($urandom_range(0, 1) == 0) write_reg(CFG_VOLTAGE_GAIN, pick_gain());
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_CURRENT_OFFSET, {12'($urandom), pick_code()});
      if ($urandom_range(0, 1) == 0) write_reg(CFG_CURRENT_GAIN, pick_gain());
      end_writes();
      n = $urandom_range(5, 40);
      for (int i = 0; i < n; i++) push_pair(pick_code(), pick_code());
      random_items += n;
    end

    drain();
    if (rms_errors == 0) begin
      $display("dual_channel_rms_meter_test: PASS");
    end else begin
      $display("dual_channel_rms_meter_test: FAIL");
    end
    $finish;
  end

endmodule
